@@ rtl/bif_pkg.sv @@
// ----------------------------------------------------------------------------
// bif_pkg
// Shared types and constants of the bilateral image filter: controller
// states, the command and status groups between controller and datapath,
// register indexes and item codes.
// ----------------------------------------------------------------------------
package bif_pkg;

  localparam int CHAN_W     = 16;
  localparam int NUM_CHAN   = 4;
  localparam int PIX_W      = CHAN_W * NUM_CHAN;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEFF   = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } bif_state_t;

  typedef struct packed {
    logic accept;
    logic centre_rd;
    logic tap_issue;
    logic div_load;
    logic div_step;
    logic out_load;
  } bif_cmd_t;

  typedef struct packed {
    logic produce;
    logic tap_last;
    logic pipe_empty;
    logic div_last;
    logic out_free;
  } bif_status_t;

endpackage

@@ rtl/bilateral_image_filter_top.sv @@
// ----------------------------------------------------------------------------
// bilateral_image_filter_top
// Streaming bilateral filter over raster-order four-channel U8.8 pixels.
// ----------------------------------------------------------------------------
// Items are taken one at a time. For an item that yields a pixel, the window
// is read one tap a cycle through the single read port of the line store,
// followed by a six-stage weight pipeline and a sixteen-step divider. Results
// wait in an output register, so the next item is taken while a result is
// still held. Output lags input by r*W + min(r, W-1) pixels; drain items flush
// the rest. The line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module bilateral_image_filter_top
  import bif_pkg::*;
#(
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_RADIUS      = 7,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [CHAN_W-1:0]     in_chan_r,
  input  logic [CHAN_W-1:0]     in_chan_g,
  input  logic [CHAN_W-1:0]     in_chan_b,
  input  logic [CHAN_W-1:0]     in_chan_a,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_r,
  output logic [CHAN_W-1:0]     out_g,
  output logic [CHAN_W-1:0]     out_b,
  output logic [CHAN_W-1:0]     out_a,
  output logic                  out_frame_last
);

  bif_cmd_t    cmd;
  bif_status_t st;

  bif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bif_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .EXP_DEPTH  (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_opcode      (in_opcode),
    .in_chan_r      (in_chan_r),
    .in_chan_g      (in_chan_g),
    .in_chan_b      (in_chan_b),
    .in_chan_a      (in_chan_a),
    .cmd            (cmd),
    .st             (st),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_r          (out_r),
    .out_g          (out_g),
    .out_b          (out_b),
    .out_a          (out_a),
    .out_frame_last (out_frame_last)
  );

endmodule

@@ rtl/bif_ram.sv @@
// ----------------------------------------------------------------------------
// bif_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bif_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bif_ctrl.sv @@
// ----------------------------------------------------------------------------
// bif_ctrl
// Sequencer: takes an item and, if it yields a result, walks centre read,
// window taps, pipeline drain, division and result hand-off.
// ----------------------------------------------------------------------------
module bif_ctrl
  import bif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  bif_status_t st,
  output bif_cmd_t    cmd
);

  bif_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && st.produce) state_nxt = ST_CENTRE;
      end
      ST_CENTRE:   state_nxt = ST_TAPS;
      ST_TAPS: begin
        if (st.tap_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (st.pipe_empty) state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (st.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_CENTRE:   cmd.centre_rd = 1'b1;
      ST_TAPS:     cmd.tap_issue = 1'b1;
      ST_DRAIN:    ;
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_DONE:     cmd.out_load = st.out_free;
      default:     ;
    endcase
  end

endmodule

@@ rtl/bif_dp.sv @@
// ----------------------------------------------------------------------------
// bif_dp
// Datapath: configuration registers, frame counters, line store ring,
// per-tap weight pipeline, accumulators, four-lane divider, output register.
// ----------------------------------------------------------------------------
module bif_dp
  import bif_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7,
  parameter int EXP_DEPTH  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_opcode,
  input  logic [CHAN_W-1:0]     in_chan_r,
  input  logic [CHAN_W-1:0]     in_chan_g,
  input  logic [CHAN_W-1:0]     in_chan_b,
  input  logic [CHAN_W-1:0]     in_chan_a,
  input  bif_cmd_t              cmd,
  output bif_status_t           st,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CHAN_W-1:0]     out_r,
  output logic [CHAN_W-1:0]     out_g,
  output logic [CHAN_W-1:0]     out_b,
  output logic [CHAN_W-1:0]     out_a,
  output logic                  out_frame_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EWW   = CW + 1;
  localparam int XW    = CW + 2;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int TW    = $clog2(2 * MAX_RADIUS + 1);
  localparam int LROWS = 2 * MAX_RADIUS + 2;
  localparam int SW    = $clog2(LROWS);
  localparam int STW   = SW + 2;
  localparam int DEPTH = LROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int XSW   = DW + 20;
  localparam int PW    = $clog2((MAX_RADIUS + 1) * MAX_WIDTH + 2);
  localparam int NTAPS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int WSW   = $clog2(NTAPS * 65536 + 1);
  localparam int ACW   = WSW + 16;
  localparam int IXW   = $clog2(EXP_DEPTH);
  localparam int DCW   = $clog2(DIV_STEPS);

  // exp(-16/D) as an alternating series, terms truncated
  localparam logic [63:0] T0  = 64'd1 << 31;
  localparam logic [63:0] T1  = T0  * 16 / (EXP_DEPTH * 1);
  localparam logic [63:0] T2  = T1  * 16 / (EXP_DEPTH * 2);
  localparam logic [63:0] T3  = T2  * 16 / (EXP_DEPTH * 3);
  localparam logic [63:0] T4  = T3  * 16 / (EXP_DEPTH * 4);
  localparam logic [63:0] T5  = T4  * 16 / (EXP_DEPTH * 5);
  localparam logic [63:0] T6  = T5  * 16 / (EXP_DEPTH * 6);
  localparam logic [63:0] T7  = T6  * 16 / (EXP_DEPTH * 7);
  localparam logic [63:0] T8  = T7  * 16 / (EXP_DEPTH * 8);
  localparam logic [63:0] T9  = T8  * 16 / (EXP_DEPTH * 9);
  localparam logic [63:0] T10 = T9  * 16 / (EXP_DEPTH * 10);
  localparam logic [63:0] T11 = T10 * 16 / (EXP_DEPTH * 11);
  localparam logic [63:0] T12 = T11 * 16 / (EXP_DEPTH * 12);
  localparam logic [63:0] EXP_BASE = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                                     + T10 - T11 + T12;

  function automatic logic [16:0] exp_entry(input int k, input logic [63:0] base);
    logic [63:0] e;
    e = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      e = (e * base + (64'd1 << 30)) >> 31;
    end
    return 17'((e + 64'd16384) >> 15);
  endfunction

  logic [16:0] lut [EXP_DEPTH];

  for (genvar k = 0; k < EXP_DEPTH; k++) begin : g_lut
    localparam logic [16:0] ENTRY = exp_entry(k, EXP_BASE);
    assign lut[k] = ENTRY;
  end

  // configuration
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  radius_r;
  logic [15:0] spatial_r;
  logic [31:0] range_r;
  logic        cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                   cfg_index == REG_WINDOW_RADIUS || cfg_index == REG_SPATIAL_COEFF ||
                   cfg_index == REG_RANGE_COEFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 11'd1024;
      height_r  <= 16'd1024;
      radius_r  <= 3'd1;
      spatial_r <= 16'd2048;
      range_r   <= 32'd3276800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_r   <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  height_r  <= cfg_data[15:0];
        REG_WINDOW_RADIUS: radius_r  <= cfg_data[2:0];
        REG_SPATIAL_COEFF: spatial_r <= cfg_data[15:0];
        REG_RANGE_COEFF:   range_r   <= cfg_data;
        default:           ;
      endcase
    end
  end

  logic [EWW-1:0] eff_w;
  logic [15:0]    eff_h;
  logic [RW-1:0]  eff_r;
  logic [EWW-1:0] rmin;
  logic [PW-1:0]  lag;

  always_comb begin
    if (width_r == 11'd0) begin
      eff_w = EWW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(width_r);
    end
    eff_h = (height_r == 16'd0) ? 16'd1 : height_r;
    eff_r = (32'(radius_r) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_r);
    rmin  = (32'(eff_r) < 32'(eff_w) - 32'd1) ? EWW'(eff_r) : eff_w - EWW'(1);
    lag   = PW'(eff_r) * PW'(eff_w) + PW'(rmin);
  end

  // frame counters
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0] pending_r, pending_nxt;
  logic          complete, is_pix;

  assign complete = in_row_r >= eff_h;
  assign is_pix   = (in_opcode == OP_PIXEL) && !complete;

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    pending_nxt  = pending_r;
    if (cfg_hit) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      pending_nxt  = '0;
    end else begin
      if (cmd.accept && is_pix) begin
        pending_nxt = pending_r + PW'(1);
        if (EWW'(in_col_r) + EWW'(1) >= eff_w) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + 16'd1;
          in_slot_nxt = (in_slot_r == SW'(LROWS - 1)) ? '0 : in_slot_r + SW'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
      if (cmd.out_load) begin
        pending_nxt = pending_r - PW'(1);
        if (EWW'(out_col_r) + EWW'(1) >= eff_w) begin
          out_col_nxt = '0;
          if (17'(out_row_r) + 17'd1 >= 17'(eff_h)) begin
            in_col_nxt   = '0;
            in_row_nxt   = '0;
            in_slot_nxt  = '0;
            out_row_nxt  = '0;
            out_slot_nxt = '0;
            pending_nxt  = '0;
          end else begin
            out_row_nxt  = out_row_r + 16'd1;
            out_slot_nxt = (out_slot_r == SW'(LROWS - 1)) ? '0 : out_slot_r + SW'(1);
          end
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pending_r  <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      pending_r  <= pending_nxt;
    end
  end

  assign st.produce = complete ||
                      (is_pix && ({1'b0, pending_r} + (PW + 1)'(1) > {1'b0, lag}));

  // tap walk
  logic [TW-1:0] ty_r, tx_r, two_r;
  logic [16:0]   sy;
  logic [XW-1:0] sx, nx;
  logic [STW-1:0] slot_a, slot_b, slot_c;
  logic          tap_ok;
  logic signed [TW:0] dxs, dys;
  logic [DW-1:0] tap_d2;
  logic [AW-1:0] tap_addr, centre_addr, raddr, waddr;
  logic [PIX_W-1:0] rdata, wdata;

  assign two_r    = TW'({eff_r, 1'b0});
  assign st.tap_last = (tx_r == two_r) && (ty_r == two_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ty_r <= '0;
      tx_r <= '0;
    end else if (cmd.centre_rd) begin
      ty_r <= '0;
      tx_r <= '0;
    end else if (cmd.tap_issue) begin
      if (tx_r == two_r) begin
        tx_r <= '0;
        ty_r <= ty_r + TW'(1);
      end else begin
        tx_r <= tx_r + TW'(1);
      end
    end
  end

  always_comb begin
    sy     = 17'(out_row_r) + 17'(ty_r);
    sx     = XW'(out_col_r) + XW'(tx_r);
    tap_ok = (sy >= 17'(eff_r)) && (sy < 17'(eff_h) + 17'(eff_r)) &&
             (sx >= XW'(eff_r)) && (sx < XW'(eff_w) + XW'(eff_r));
    nx     = sx - XW'(eff_r);
    slot_a = STW'(out_slot_r) + STW'(LROWS) + STW'(ty_r) - STW'(eff_r);
    slot_b = (slot_a >= STW'(LROWS)) ? slot_a - STW'(LROWS) : slot_a;
    slot_c = (slot_b >= STW'(LROWS)) ? slot_b - STW'(LROWS) : slot_b;
    dxs    = $signed({1'b0, tx_r}) - $signed((TW + 1)'(eff_r));
    dys    = $signed({1'b0, ty_r}) - $signed((TW + 1)'(eff_r));
    tap_d2 = DW'(dxs * dxs) + DW'(dys * dys);
    tap_addr    = AW'(slot_c[SW-1:0]) * AW'(MAX_WIDTH) + AW'(nx[CW-1:0]);
    centre_addr = AW'(out_slot_r) * AW'(MAX_WIDTH) + AW'(out_col_r);
    raddr       = cmd.centre_rd ? centre_addr : tap_addr;
    waddr       = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
    wdata       = {in_chan_a, in_chan_b, in_chan_g, in_chan_r};
  end

  bif_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.accept && is_pix),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // weight pipeline
  logic             cen_pend_r;
  logic [PIX_W-1:0] centre_r;
  logic             p0_v_r, p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r;
  logic             p0_ok_r, p1_ok_r, p2_ok_r, p3_ok_r, p4_ok_r;
  logic [DW-1:0]    p0_d2_r, p1_d2_r;
  logic [PIX_W-1:0] p1_pix_r, p2_pix_r, p3_pix_r, p4_pix_r, p5_pix_r;
  logic [31:0]      p1_sq_r [NUM_CHAN];
  logic [33:0]      p2_cd2_r;
  logic [XSW-1:0]   p2_xs_r, p3_xs_r;
  logic [48:0]      p3_pl_r, p3_ph_r;
  logic [19:0]      p4_x_r;
  logic [16:0]      p5_wt_r;
  logic [66:0]      rprod;
  logic [XSW:0]     xsum;
  logic [32:0]      ixp;
  logic [IXW-1:0]   idx;
  logic [CHAN_W-1:0] da [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      da[c] = (centre_r[CHAN_W*c +: CHAN_W] > rdata[CHAN_W*c +: CHAN_W]) ?
              centre_r[CHAN_W*c +: CHAN_W] - rdata[CHAN_W*c +: CHAN_W] :
              rdata[CHAN_W*c +: CHAN_W] - centre_r[CHAN_W*c +: CHAN_W];
    end
    rprod = {p3_ph_r, 17'd0} + 67'(p3_pl_r);
    xsum  = (XSW + 1)'(p3_xs_r) + (XSW + 1)'(rprod[35:16]);
    ixp   = 33'(p4_x_r) * 33'(EXP_DEPTH);
    idx   = ixp[IXW+19:20];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_pend_r <= 1'b0;
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
    end else begin
      cen_pend_r <= cmd.centre_rd;
      p0_v_r <= cmd.tap_issue;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cen_pend_r) begin
      centre_r <= rdata;
    end
    p0_ok_r  <= tap_ok;
    p0_d2_r  <= tap_d2;
    p1_ok_r  <= p0_ok_r;
    p1_d2_r  <= p0_d2_r;
    p1_pix_r <= rdata;
    for (int c = 0; c < NUM_CHAN; c++) begin
      p1_sq_r[c] <= 32'(da[c]) * 32'(da[c]);
    end
    p2_ok_r  <= p1_ok_r;
    p2_pix_r <= p1_pix_r;
    p2_cd2_r <= 34'(p1_sq_r[0]) + 34'(p1_sq_r[1]) + 34'(p1_sq_r[2]) + 34'(p1_sq_r[3]);
    p2_xs_r  <= (XSW'(p1_d2_r) * XSW'(spatial_r)) << 4;
    p3_ok_r  <= p2_ok_r;
    p3_pix_r <= p2_pix_r;
    p3_xs_r  <= p2_xs_r;
    p3_pl_r  <= 49'(p2_cd2_r[16:0]) * 49'(range_r);
    p3_ph_r  <= 49'(p2_cd2_r[33:17]) * 49'(range_r);
    p4_ok_r  <= p3_ok_r && (rprod[66:36] == '0) && (xsum[XSW:20] == '0);
    p4_x_r   <= xsum[19:0];
    p4_pix_r <= p3_pix_r;
    p5_wt_r  <= p4_ok_r ? lut[idx] : 17'd0;
    p5_pix_r <= p4_ok_r ? p4_pix_r : '0;
  end

  assign st.pipe_empty = !(p0_v_r || p1_v_r || p2_v_r || p3_v_r || p4_v_r || p5_v_r);

  // accumulate
  logic [ACW-1:0] acc_r [NUM_CHAN];
  logic [WSW-1:0] wsum_r;

  always_ff @(posedge clk) begin
    if (cmd.centre_rd) begin
      wsum_r <= '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        acc_r[c] <= '0;
      end
    end else if (p5_v_r) begin
      wsum_r <= wsum_r + WSW'(p5_wt_r);
      for (int c = 0; c < NUM_CHAN; c++) begin
        acc_r[c] <= acc_r[c] + ACW'(p5_wt_r) * ACW'(p5_pix_r[CHAN_W*c +: CHAN_W]);
      end
    end
  end

  // divide: one quotient bit per cycle in each lane
  logic [WSW:0]     rem_r [NUM_CHAN];
  logic [15:0]      quo_r [NUM_CHAN];
  logic [DCW-1:0]   div_cnt_r;
  logic [ACW:0]     num [NUM_CHAN];
  logic [WSW+1:0]   trial [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      num[c]   = (ACW + 1)'(acc_r[c]) + (ACW + 1)'(wsum_r >> 1);
      trial[c] = {rem_r[c], quo_r[c][15]};
    end
  end

  assign st.div_last = (div_cnt_r == DCW'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_cnt_r <= '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem_r[c] <= num[c][ACW:16];
        quo_r[c] <= num[c][15:0];
      end
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DCW'(1);
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (trial[c] >= (WSW + 2)'(wsum_r)) begin
          rem_r[c] <= (WSW + 1)'(trial[c] - (WSW + 2)'(wsum_r));
          quo_r[c] <= {quo_r[c][14:0], 1'b1};
        end else begin
          rem_r[c] <= trial[c][WSW:0];
          quo_r[c] <= {quo_r[c][14:0], 1'b0};
        end
      end
    end
  end

  // result register
  logic              out_valid_r;
  logic [CHAN_W-1:0] res_r [NUM_CHAN];
  logic              last_r;

  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        res_r[c] <= quo_r[c];
      end
      last_r <= (EWW'(out_col_r) + EWW'(1) == eff_w) && (17'(out_row_r) + 17'd1 == 17'(eff_h));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r          = res_r[0];
  assign out_g          = res_r[1];
  assign out_b          = res_r[2];
  assign out_a          = res_r[3];
  assign out_frame_last = last_r;

endmodule

@@ tb/bilateral_image_filter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilateral_image_filter_top_tb
// Self-checking bench for the streaming bilateral filter. A behavioural copy
// of the filter (line store, exponential table, windowed weighted mean)
// predicts every output pixel. Directed frames cover the register extremes,
// drain handling and edge images. Random frames of small size then run under
// three idling patterns. A last frame sees a long output hold and a sender pause.
// ----------------------------------------------------------------------------
module bilateral_image_filter_top_tb;
  import bif_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_R      = 7;
  localparam int LUT_DEPTH  = 256;
  localparam int RING_ROWS  = 2 * MAX_R + 2;
  localparam int SETTLE     = 400;
  localparam int CYCLE_CAP  = 6000000;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
    logic              frame_last;
  } filtered_pix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_opcode;
  logic [CHAN_W-1:0]     in_chan_r, in_chan_g, in_chan_b, in_chan_a;
  logic                  out_valid;
  logic                  out_stall;
  logic [CHAN_W-1:0]     out_r, out_g, out_b, out_a;
  logic                  out_frame_last;

  bilateral_image_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_chan_r(in_chan_r), .in_chan_g(in_chan_g),
    .in_chan_b(in_chan_b), .in_chan_a(in_chan_a),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r(out_r), .out_g(out_g), .out_b(out_b), .out_a(out_a),
    .out_frame_last(out_frame_last)
  );

  // filter model state
  logic [PIX_W-1:0]  line_mem [RING_ROWS*MAX_W];
  logic [31:0]       exp_q16 [LUT_DEPTH];
  int unsigned       px_col, px_row, res_col, res_row;
  logic [10:0]       img_w;
  logic [15:0]       img_h;
  logic [2:0]        win_r;
  logic [15:0]       sp_coeff;
  logic [31:0]       rg_coeff;

  filtered_pix_t     pending_pix [$];
  int                errors;
  int                items_sent;
  int                cycles;
  int                tx_idle, rx_idle;
  int                hold_left;
  logic [CHAN_W-1:0] base_level;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned eff_w();
    if (img_w == 0) return 1;
    return (img_w > MAX_W) ? MAX_W : img_w;
  endfunction

  function automatic int unsigned eff_h();
    return (img_h == 0) ? 1 : img_h;
  endfunction

  function automatic int unsigned eff_r();
    return (win_r > MAX_R) ? MAX_R : win_r;
  endfunction

  function automatic void build_exp_table();
    logic [63:0] term, base, e;
    term = 64'd1 << 31;
    base = term;
    e    = term;
    for (int m = 1; m <= 12; m++) begin
      term = term * 16 / (LUT_DEPTH * m);
      if (m % 2) base = base - term;
      else base = base + term;
    end
    for (int k = 0; k < LUT_DEPTH; k++) begin
      if (k > 0) e = (e * base + (64'd1 << 30)) >> 31;
      exp_q16[k] = 32'((e + 64'd16384) >> 15);
    end
  endfunction

  function automatic logic [63:0] chan_of(logic [PIX_W-1:0] p, int c);
    return 64'(p[16*c +: 16]);
  endfunction

  function automatic filtered_pix_t filter_pixel();
    int          w, h, rad, ox, oy, nx, ny;
    logic [PIX_W-1:0] centre, nb;
    logic [63:0] acc [4];
    logic [63:0] wsum, rlim, cd2, x, wt, d, ca, cb, res [4];
    filtered_pix_t o;
    w = eff_w(); h = eff_h(); rad = eff_r();
    ox = res_col; oy = res_row;
    centre = line_mem[(oy % RING_ROWS) * MAX_W + ox];
    for (int c = 0; c < 4; c++) acc[c] = 0;
    wsum = 0;
    rlim = (rg_coeff != 0) ? ((64'd1 << 36) + rg_coeff - 1) / rg_coeff : 0;
    for (int dy = -rad; dy <= rad; dy++) begin
      ny = oy + dy;
      if (ny < 0 || ny >= h) continue;
      for (int dx = -rad; dx <= rad; dx++) begin
        nx = ox + dx;
        if (nx < 0 || nx >= w) continue;
        nb = line_mem[(ny % RING_ROWS) * MAX_W + nx];
        cd2 = 0;
        for (int c = 0; c < 4; c++) begin
          ca = chan_of(centre, c);
          cb = chan_of(nb, c);
          d = (ca > cb) ? ca - cb : cb - ca;
          cd2 += d * d;
        end
        x = (64'(dx * dx + dy * dy) * sp_coeff) << 4;
        if (rg_coeff != 0) begin
          if (cd2 >= rlim) continue;
          x += (cd2 * rg_coeff) >> 16;
        end
        if (x >= (64'd1 << 20)) continue;
        wt = exp_q16[(x * LUT_DEPTH) >> 20];
        for (int c = 0; c < 4; c++) acc[c] += wt * chan_of(nb, c);
        wsum += wt;
      end
    end
    for (int c = 0; c < 4; c++)
      res[c] = (wsum != 0) ? (acc[c] + wsum / 2) / wsum : chan_of(centre, c);
    o.r = res[0][15:0]; o.g = res[1][15:0]; o.b = res[2][15:0]; o.a = res[3][15:0];
    o.frame_last = (ox == w - 1 && oy == h - 1);
    res_col++;
    if (res_col >= w) begin
      res_col = 0;
      res_row++;
      if (res_row >= h) begin
        px_col = 0; px_row = 0; res_col = 0; res_row = 0;
      end
    end
    return o;
  endfunction

  function automatic void filter_step(logic op, logic [CHAN_W-1:0] r, g, b, a);
    int unsigned   w, h, rad, lag, recv, sent;
    bit            complete;
    filtered_pix_t nxt_pix;
    w = eff_w(); h = eff_h(); rad = eff_r();
    complete = px_row >= h;
    if (op == OP_PIXEL && !complete) begin
      line_mem[(px_row % RING_ROWS) * MAX_W + px_col] = {a, b, g, r};
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row++;
      end
      lag  = rad * w + ((rad < w - 1) ? rad : w - 1);
      recv = px_row * w + px_col;
      sent = res_row * w + res_col;
      if (recv - sent > lag) begin
        nxt_pix = filter_pixel();
        pending_pix = {pending_pix, nxt_pix};
      end
    end else if (complete) begin
      nxt_pix = filter_pixel();
      pending_pix = {pending_pix, nxt_pix};
    end
  endfunction

  always @(posedge clk) begin
    filtered_pix_t exp_pix;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected output pixel r=%h g=%h b=%h a=%h", out_r, out_g, out_b, out_a);
        errors++;
      end else begin
        exp_pix = pending_pix.pop_front();
        if (out_r !== exp_pix.r) begin
          $error("out_r expected %h actual %h", exp_pix.r, out_r); errors++;
        end
        if (out_g !== exp_pix.g) begin
          $error("out_g expected %h actual %h", exp_pix.g, out_g); errors++;
        end
        if (out_b !== exp_pix.b) begin
          $error("out_b expected %h actual %h", exp_pix.b, out_b); errors++;
        end
        if (out_a !== exp_pix.a) begin
          $error("out_a expected %h actual %h", exp_pix.a, out_a); errors++;
        end
        if (out_frame_last !== exp_pix.frame_last) begin
          $error("out_frame_last expected %b actual %b", exp_pix.frame_last,
                 out_frame_last);
          errors++;
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever @(negedge clk) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  task automatic send_item(logic op, logic [CHAN_W-1:0] r, g, b, a);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_chan_r <= r; in_chan_g <= g; in_chan_b <= b; in_chan_a <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    filter_step(op, r, g, b, a);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    go_quiet();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   img_w    = val[10:0];
      REG_IMAGE_HEIGHT:  img_h    = val[15:0];
      REG_WINDOW_RADIUS: win_r    = val[2:0];
      REG_SPATIAL_COEFF: sp_coeff = val[15:0];
      REG_RANGE_COEFF:   rg_coeff = val;
      default: ;
    endcase
    px_col = 0; px_row = 0; res_col = 0; res_row = 0;
  endtask

  task automatic set_frame(int w, int h, int rad, int sc, logic [31:0] rc);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RADIUS, rad);
    write_reg(REG_SPATIAL_COEFF, sc);
    write_reg(REG_RANGE_COEFF, rc);
  endtask

  function automatic logic [CHAN_W-1:0] pick_chan();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return base_level + CHAN_W'($urandom_range(255)) - 16'd128;
    if (sel < 80) return CHAN_W'($urandom);
    return sel[0] ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic send_pixel();
    send_item(OP_PIXEL, pick_chan(), pick_chan(), pick_chan(), pick_chan());
  endtask

  // feed one whole frame, with stray drains if noisy is set, then flush it
  task automatic run_frame(int n_pix, bit noisy);
    base_level = CHAN_W'($urandom);
    for (int i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(OP_DRAIN, CHAN_W'($urandom), CHAN_W'($urandom), 0, 0);
      send_pixel();
    end
    while (px_row >= eff_h()) begin
      if ($urandom_range(3) == 0) send_pixel();
      else send_item(OP_DRAIN, 0, 0, 0, 0);
    end
  endtask

  task automatic test_reset_values();
    send_pixel();
    send_pixel();
    send_item(OP_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel();
  endtask

  task automatic test_tiny_frames();
    set_frame(1, 1, 0, 2048, 32'd3276800);
    send_item(OP_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(OP_DRAIN, 0, 0, 0, 0);
    set_frame(0, 0, 7, 0, 0);
    send_item(OP_PIXEL, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    set_frame(3, 2, 7, 0, 0);
    run_frame(6, 0);
  endtask

  task automatic test_coeff_extremes();
    set_frame(4, 3, 1, 65535, 32'hFFFF_FFFF);
    run_frame(12, 1);
    set_frame(5, 3, 2, 1, 1);
    run_frame(15, 1);
  endtask

  task automatic test_size_extremes();
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    for (int i = 0; i < 4; i++) send_pixel();
    set_frame(2, 65535, 1, 2048, 32'd3276800);
    for (int i = 0; i < 8; i++) send_pixel();
    write_reg(REG_IMAGE_WIDTH, 1025);
    send_pixel();
  endtask

  task automatic random_frames(int quota);
    int start, w, h, rad;
    start = items_sent;
    while (items_sent - start < quota) begin
      rad = ($urandom_range(9) == 0) ? 7 : $urandom_range(3);
      w   = (rad == 7) ? $urandom_range(1, 8) : $urandom_range(1, 14);
      h   = (rad == 7) ? $urandom_range(1, 4) : $urandom_range(1, 8);
      if ($urandom_range(7) == 0) w = $urandom_range(20, 40);
      set_frame(w, h, rad, $urandom_range(65535) >> $urandom_range(15),
                $urandom >> $urandom_range(31));
      run_frame(w * h, 1);
    end
  endtask

  task automatic test_output_hold();
    rx_idle = 0; tx_idle = 0;
    set_frame(8, 6, 1, 2048, 32'd3276800);
    hold_left = 3000;
    base_level = CHAN_W'($urandom);
    for (int i = 0; i < 24; i++) send_pixel();
    go_quiet();
    for (int i = 0; i < 24; i++) send_pixel();
    while (px_row >= eff_h()) send_item(OP_DRAIN, 0, 0, 0, 0);
  endtask

  initial begin
    errors = 0; items_sent = 0; cycles = 0; hold_left = 0;
    tx_idle = 23; rx_idle = 77;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_opcode = OP_PIXEL;
    in_chan_r = '0; in_chan_g = '0; in_chan_b = '0; in_chan_a = '0;
    img_w = 11'd1024; img_h = 16'd1024; win_r = 3'd1;
    sp_coeff = 16'd2048; rg_coeff = 32'd3276800;
    px_col = 0; px_row = 0; res_col = 0; res_row = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    build_exp_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_tiny_frames();
    test_coeff_extremes();
    test_size_extremes();
    random_frames(540);
    tx_idle = 77; rx_idle = 23;
    random_frames(540);
    tx_idle = 0; rx_idle = 0;
    random_frames(540);
    test_output_hold();

    go_quiet();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_pix.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
